### src/hmc_pkg.sv
// Shared types and constants for the Huffman merge-cost block.
// No dependencies; used by hmc_cell and huffman_merge_cost.
package hmc_pkg;
	localparam int WEIGHT_W = 16;
	localparam int COST_W   = 36;
	localparam int TDATA_W  = 40;

	// Operation broadcast to every cell of the row in the same cycle.
	typedef struct packed {
		logic ins;  // sorted insert of a loaded weight
		logic mrg;  // drop the two smallest, insert their sum
	} cell_op_t;
endpackage

### src/huffman_merge_cost.sv
// Huffman minimum merge cost: loads weights into a sorted row of cells, then merges.
// After the last weight, merges run until fewer than two entries remain; the result is then registered and presented.
// Throughput: one weight per cycle while loading; no input is taken until the result is taken.
// Each merge pops the two smallest and reinserts their sum across the row; all cells update in the same cycle.
// Reset (arst_n low, asynchronous) empties the row and clears cost and overflow flag.
// Depends on hmc_pkg and hmc_cell.
module huffman_merge_cost #(
	parameter int CAPACITY = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [hmc_pkg::WEIGHT_W-1:0] s_tdata,   // [15:0] weight
	input  logic                        s_tlast,   // last_item
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [hmc_pkg::TDATA_W-1:0] m_tdata,   // [35:0] total_cost, [39:36] zero
	output logic                        m_tuser    // [0] status
);
	localparam int VW = hmc_pkg::WEIGHT_W + $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_MERGE = 2'd1;
	localparam logic [1:0] ST_OUT   = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] count_q;
	logic [hmc_pkg::COST_W-1:0] cost_q;
	logic          ovf_q;
	logic [hmc_pkg::COST_W-1:0] res_cost_q;
	logic          res_stat_q;

	logic [VW-1:0] val   [CAPACITY+2];
	logic          vld   [CAPACITY+2];
	logic [VW-1:0] key, sum;
	logic          acc, room, do_merge;
	hmc_pkg::cell_op_t op;

	assign s_tready = (state_q == ST_LOAD);
	assign acc      = s_tvalid && s_tready;
	assign room     = (count_q < CW'(CAPACITY));
	assign do_merge = (state_q == ST_MERGE) && (count_q >= CW'(2));
	assign sum      = val[0] + val[1];
	assign key      = (state_q == ST_MERGE) ? sum : VW'(s_tdata);
	assign op.ins   = acc && room;
	assign op.mrg   = do_merge;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_row
		assign vld[i] = (count_q > CW'(i));
		hmc_cell #(.VW(VW), .FIRST(i == 0)) u_cell (
			.clk(clk), .op(op), .key(key),
			.prev_vld(vld[(i == 0) ? 0 : i - 1]), .prev_val(val[(i == 0) ? 0 : i - 1]),
			.self_vld(vld[i]),
			.next1_val(val[i + 1]), .next1_vld(vld[i + 1]),
			.next2_val(val[i + 2]), .next2_vld(vld[i + 2]),
			.val_q(val[i])
		);
	end
	assign val[CAPACITY]     = '0;
	assign vld[CAPACITY]     = 1'b0;
	assign val[CAPACITY + 1] = '0;
	assign vld[CAPACITY + 1] = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			cost_q  <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (acc) begin
						if (room)
							count_q <= count_q + CW'(1);
						else
							ovf_q <= 1'b1;
						if (s_tlast)
							state_q <= ST_MERGE;
					end
				end
				ST_MERGE: begin
					if (do_merge) begin
						count_q <= count_q - CW'(1);
						cost_q  <= cost_q + hmc_pkg::COST_W'(sum);
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// drop the set once the result transaction completes
					if (m_tready) begin
						state_q <= ST_LOAD;
						count_q <= '0;
						cost_q  <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MERGE && !do_merge) begin
			res_cost_q <= cost_q;
			res_stat_q <= ovf_q;
		end
	end

	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = hmc_pkg::TDATA_W'(res_cost_q);
	assign m_tuser  = res_stat_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY)) else $error("entry count beyond capacity");
	a_merge_dec: assert property (@(posedge clk) disable iff (!arst_n)
		do_merge |=> count_q == $past(count_q) - CW'(1)) else $error("merge did not shrink row");
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE && count_q >= CW'(2)) |-> val[0] <= val[1])
		else $error("row head out of order");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !m_tready) |=> state_q == ST_OUT && !s_tready)
		else $error("result left before taken");
endmodule

### src/hmc_cell.sv
// One cell of the sorted row: holds one value and takes a new one from itself, its neighbors or the key.
// Depends on hmc_pkg (cell_op_t).
module hmc_cell #(
	parameter int VW    = 26,
	parameter bit FIRST = 1'b0
) (
	input  logic              clk,
	input  hmc_pkg::cell_op_t op,
	input  logic [VW-1:0]     key,       // value being placed this cycle
	input  logic              prev_vld,
	input  logic [VW-1:0]     prev_val,
	input  logic              self_vld,
	input  logic [VW-1:0]     next1_val,
	input  logic              next1_vld,
	input  logic [VW-1:0]     next2_val,
	input  logic              next2_vld,
	output logic [VW-1:0]     val_q
);
	logic le_self, le_prev, le1, le2;
	logic [VW-1:0] nxt;

	assign le_self = self_vld && (val_q <= key);
	assign le_prev = !FIRST && prev_vld && (prev_val <= key);
	assign le1     = next1_vld && (next1_val <= key);
	assign le2     = next2_vld && (next2_val <= key);

	always_comb begin
		nxt = val_q;
		if (op.ins) begin
			if (le_self)
				nxt = val_q;
			else if (FIRST || le_prev)
				nxt = key;
			else
				nxt = prev_val;
		end else if (op.mrg) begin
			if (le2)
				nxt = next2_val;
			else if (!FIRST && !le1)
				nxt = next1_val;
			else
				nxt = key;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= nxt;
	end
endmodule

### tb/sv/tb_huffman_merge_cost.sv
// Testbench for huffman_merge_cost: streams weight sets and checks each merge cost and status.
// Depends on hmc_pkg and huffman_merge_cost; the costs come from an optimal-merge predictor.
`timescale 1ns / 100ps

module tb_huffman_merge_cost;
	localparam int WEIGHT_W = hmc_pkg::WEIGHT_W;
	localparam int COST_W   = hmc_pkg::COST_W;
	localparam int TDATA_W  = hmc_pkg::TDATA_W;

	localparam int CAP = 1024;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [COST_W-1:0] cost;
		logic              ovf;
	} merge_res_t;

	typedef struct {
		logic [WEIGHT_W-1:0] weight;
		logic                last;
		logic                known;  // expected result typed in below
		logic [COST_W-1:0]   cost;
		logic                ovf;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [WEIGHT_W-1:0] s_tdata;
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [TDATA_W-1:0]  m_tdata;
	logic                m_tuser;

	merge_res_t          pending_costs[$];
	logic [WEIGHT_W-1:0] set_weights[$];
	logic                set_dropped;
	int                  errors;
	int                  idle_cycles;

	huffman_merge_cost #(.CAPACITY(CAP)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string what);
		$display("%0t: mismatch: %s", $time, what);
		errors++;
	endtask

	// Optimal merge cost: sorted leaves plus a queue of sums, which never decrease.
	function automatic logic [COST_W-1:0] merge_cost(input logic [WEIGHT_W-1:0] ws[$]);
		logic [63:0] leaves[$];
		logic [63:0] sums[$];
		logic [63:0] pick[2];
		logic [63:0] total;
		total = 0;
		foreach (ws[i]) leaves.push_back(64'(ws[i]));
		leaves.sort();
		while (leaves.size() + sums.size() >= 2) begin
			for (int k = 0; k < 2; k++) begin
				if (sums.size() == 0 || (leaves.size() != 0 && leaves[0] <= sums[0]))
					pick[k] = leaves.pop_front();
				else
					pick[k] = sums.pop_front();
			end
			sums.push_back(pick[0] + pick[1]);
			total += pick[0] + pick[1];
		end
		return total[COST_W-1:0];
	endfunction

	// Drive one weight, hold until the transaction, then update the predicted set.
	task automatic send(input logic [WEIGHT_W-1:0] w, input logic last);
		merge_res_t r;
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		s_tlast  <= last;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		if (set_weights.size() < CAP) set_weights.push_back(w);
		else set_dropped = 1'b1;
		if (last) begin
			r.cost = merge_cost(set_weights);
			r.ovf  = set_dropped;
			pending_costs.push_back(r);
			set_weights.delete();
			set_dropped = 1'b0;
		end
	endtask

	// Sender burst state: gaps fall between random-length bursts.
	int burst_left = 0;

	task automatic send_paced(input logic [WEIGHT_W-1:0] w, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			// drop valid only when a gap actually follows
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		send(w, last);
	endtask

	function automatic logic [WEIGHT_W-1:0] rand_weight();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return WEIGHT_W'($urandom_range(0, 15));
			default: return WEIGHT_W'($urandom);
		endcase
	endfunction

	// Receiver: random stretches that are free-flowing, stall-heavy or ready about half the time.
	int rx_mode = 0;
	int rx_left = 0;
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_left = $urandom_range(5, 60);
		end
		rx_left--;
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= $urandom_range(0, 1);
		endcase
	end

	always @(posedge clk) begin
		merge_res_t exp_r;
		if (m_tvalid && m_tready) begin
			if (pending_costs.size() == 0) begin
				report("result with nothing expected");
			end else begin
				exp_r = pending_costs.pop_front();
				if (m_tdata[COST_W-1:0] !== exp_r.cost)
					report($sformatf("total_cost %0d, expected %0d",
						m_tdata[COST_W-1:0], exp_r.cost));
				if (m_tdata[TDATA_W-1:COST_W] !== '0)
					report("tdata padding not zero");
				if (m_tuser !== exp_r.ovf)
					report($sformatf("status %0b, expected %0b", m_tuser, exp_r.ovf));
			end
		end
	end

	// Watchdog on cycles with no transaction on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_huffman_merge_cost failed");
			$finish;
		end
	end

	stim_row_t table_rows[$];
	int set_len;

	initial begin
		errors      = 0;
		idle_cycles = 0;
		set_dropped = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		m_tready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// weight, last, known, cost, status
		table_rows = '{
			'{16'd0,     1'b1, 1'b1, 36'd0,      1'b0},
			'{16'hFFFF,  1'b1, 1'b1, 36'd0,      1'b0},
			'{16'hFFFF,  1'b0, 1'b0, 36'd0,      1'b0},
			'{16'hFFFF,  1'b1, 1'b1, 36'd131070, 1'b0},
			'{16'd0,     1'b0, 1'b0, 36'd0,      1'b0},
			'{16'd0,     1'b1, 1'b1, 36'd0,      1'b0},
			'{16'd1,     1'b0, 1'b0, 36'd0,      1'b0},
			'{16'd2,     1'b0, 1'b0, 36'd0,      1'b0},
			'{16'd3,     1'b1, 1'b1, 36'd9,      1'b0},
			'{16'h5555,  1'b0, 1'b0, 36'd0,      1'b0},
			'{16'hAAAA,  1'b0, 1'b0, 36'd0,      1'b0},
			'{16'd7,     1'b0, 1'b0, 36'd0,      1'b0},
			'{16'h8000,  1'b0, 1'b0, 36'd0,      1'b0},
			'{16'd7,     1'b1, 1'b0, 36'd0,      1'b0}
		};
		foreach (table_rows[i]) begin
			send_paced(table_rows[i].weight, table_rows[i].last);
			if (table_rows[i].known && (pending_costs[$].cost !== table_rows[i].cost
					|| pending_costs[$].ovf !== table_rows[i].ovf))
				report($sformatf("predictor disagrees with table row %0d", i));
		end

		// Fill the store, then offer two more; the second extra carries last and is dropped.
		for (int i = 0; i < CAP + 2; i++) send_paced(rand_weight(), i == CAP + 1);

		for (int n = 0; n < 210; n += set_len) begin
			set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
			for (int i = 0; i < set_len; i++) send_paced(rand_weight(), i == set_len - 1);
		end
		s_tvalid <= 1'b0;

		while (pending_costs.size() != 0) @(posedge clk);
		repeat (CAP + 20) @(posedge clk);
		if (errors == 0) begin
			$display("tb_huffman_merge_cost passed");
		end else begin
			$display("tb_huffman_merge_cost failed");
		end
		$finish;
	end
endmodule
